@@ src/knx_rx_frame_checker_macros.svh @@
// Assertion macros shared by the frame checker RTL.
`ifndef KNX_RX_FRAME_CHECKER_MACROS_SVH
`define KNX_RX_FRAME_CHECKER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define KNXRX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define KNXRX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/knxrx_pkg.sv @@
// Types and constants of the bus frame receive checker.
package knxrx_pkg;

  localparam int HDR_DEPTH = 7;
  localparam logic [8:0] COUNT_MAX = 9'd511;
  localparam logic [8:0] STD_MIN_LEN = 9'd8;
  localparam logic [8:0] EXT_MIN_LEN = 9'd9;
  localparam logic [7:0] CTRL_STD_MASK = 8'h80;
  localparam logic [7:0] LEN_FIELD_MASK = 8'h0F;
  localparam logic [7:0] CTRL_REP_MASK = 8'h20;
  localparam logic [7:0] CTRL_PRI_MASK = 8'h0C;
  localparam logic [7:0] HOP_MASK = 8'h07;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_RUNT      = 3'd1,
    ST_TRUNCATED = 3'd2,
    ST_CHECK_ERR = 3'd3,
    ST_REP_DROP  = 3'd4
  } status_t;

  // One received octet request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_t;

  // One frame result request
  typedef struct packed {
    status_t     status;
    logic        extended_frame;
    logic        trimmed;
    logic        group_address;
    logic [15:0] source_address;
    logic [15:0] destination_address;
    logic [1:0]  priority_res;
    logic [2:0]  routing_hops;
    logic [8:0]  lsdu_length;
    logic        repeated;
  } result_t;

  typedef logic [HDR_DEPTH-1:0][7:0] hdr_bytes_t;

  // Fields decoded from the header octets
  typedef struct packed {
    logic        std_format;
    logic [8:0]  full_len;
    logic        group_address;
    logic [15:0] source_address;
    logic [15:0] destination_address;
    logic [1:0]  priority_res;
    logic [2:0]  routing_hops;
    logic [8:0]  lsdu_length;
    logic        repeated;
  } hdr_info_t;

endpackage

@@ src/knxrx_hdr_decode.sv @@
// Header decode: frame format, expected length and address fields.
module knxrx_hdr_decode (
  input  knxrx_pkg::hdr_bytes_t hdr,
  output knxrx_pkg::hdr_info_t  info
);

  logic [7:0] ext_len_byte;
  logic [7:0] std_len_byte;
  logic [7:0] std_hop_byte;
  logic [7:0] ext_hop_byte;
  logic [7:0] pri_byte;

  assign std_len_byte = hdr[5] & knxrx_pkg::LEN_FIELD_MASK;
  assign ext_len_byte = hdr[6];
  assign std_hop_byte = (hdr[5] >> 4) & knxrx_pkg::HOP_MASK;
  assign ext_hop_byte = (hdr[1] >> 4) & knxrx_pkg::HOP_MASK;
  assign pri_byte     = (hdr[0] & knxrx_pkg::CTRL_PRI_MASK) >> 2;

  always_comb begin
    info.std_format = (hdr[0] & knxrx_pkg::CTRL_STD_MASK) != 8'h00;
    info.priority_res = pri_byte[1:0];
    info.repeated = (hdr[0] & knxrx_pkg::CTRL_REP_MASK) == 8'h00;
    if (info.std_format) begin
      // standard: length nibble in octet 5, addresses in octets 1 to 4
      info.full_len = knxrx_pkg::STD_MIN_LEN + {1'b0, std_len_byte};
      info.group_address = hdr[5][7];
      info.source_address = {hdr[1], hdr[2]};
      info.destination_address = {hdr[3], hdr[4]};
      info.routing_hops = std_hop_byte[2:0];
      info.lsdu_length = {1'b0, std_len_byte} + 9'd1;
    end else begin
      // extended: octet 1 carries routing, length octet 6
      info.full_len = knxrx_pkg::EXT_MIN_LEN + {1'b0, ext_len_byte};
      info.group_address = hdr[1][7];
      info.source_address = {hdr[2], hdr[3]};
      info.destination_address = {hdr[4], hdr[5]};
      info.routing_hops = ext_hop_byte[2:0];
      info.lsdu_length = {1'b0, ext_len_byte} + 9'd1;
    end
  end

endmodule

@@ src/knx_rx_frame_checker.sv @@
// A final octet goes through the input register, then the result register.
// Takes one octet per cycle unless byte_stall is raised; one input register and one result register,
// the frame state updates in a single pass between them.
// A final octet waits in the input register only while an earlier result is stalled.
// Reset (rst, synchronous) clears counters, running XOR, prior identity and valids;
// header octets are not cleared, each frame overwrites them before use.
`include "knx_rx_frame_checker_macros.svh"

module knx_rx_frame_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  knxrx_pkg::byte_t   byte_item,
  output logic               result_valid,
  input  logic               result_stall,
  output knxrx_pkg::result_t result_item
);

  // input register
  logic             in_valid;
  knxrx_pkg::byte_t in_reg;

  // frame state
  logic [8:0]            byte_count;
  logic [7:0]            running_xor;
  logic [7:0]            check_byte;
  knxrx_pkg::hdr_bytes_t header_store;

  // identity of the last good frame
  logic        prior_valid;
  logic [15:0] prior_source;
  logic [15:0] prior_destination;
  logic [8:0]  prior_length;
  logic [7:0]  prior_check;

  logic                  process;
  knxrx_pkg::hdr_bytes_t hdr_cur;
  knxrx_pkg::hdr_info_t  info;
  logic [8:0]            byte_count_next;
  logic [7:0]            running_xor_next;
  logic [7:0]            check_byte_next;
  logic [8:0]            idx_plus;
  logic [7:0]            norm_check;
  logic                  rep_match;
  logic                  update_prior;
  knxrx_pkg::result_t    res;

  // a final octet moves on only when the result register can take it
  assign process    = in_valid && (!in_reg.last_byte || !result_valid || !result_stall);
  assign byte_stall = in_valid && !process;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!byte_stall) begin
      in_valid <= byte_valid;
    end
    if (!byte_stall && byte_valid) begin
      in_reg <= byte_item;
    end
  end

  // header as seen after this octet is written
  always_comb begin
    hdr_cur = header_store;
    if (byte_count < 9'(knxrx_pkg::HDR_DEPTH)) begin
      hdr_cur[byte_count[2:0]] = in_reg.data_byte;
    end
  end

  knxrx_hdr_decode u_decode (
    .hdr  (hdr_cur),
    .info (info)
  );

  // per-octet update of count, XOR and check octet
  assign idx_plus = byte_count + 9'd1;

  always_comb begin
    running_xor_next = running_xor;
    check_byte_next  = check_byte;
    if (byte_count < 9'(knxrx_pkg::HDR_DEPTH)) begin
      running_xor_next = running_xor ^ in_reg.data_byte;
    end else if (byte_count < knxrx_pkg::COUNT_MAX) begin
      if (idx_plus < info.full_len) begin
        running_xor_next = running_xor ^ in_reg.data_byte;
      end else if (idx_plus == info.full_len) begin
        check_byte_next = in_reg.data_byte;
      end
    end
    byte_count_next = (byte_count == knxrx_pkg::COUNT_MAX) ? byte_count : idx_plus;
  end

  // end-of-frame verdict
  assign norm_check = check_byte_next ^ (info.repeated ? knxrx_pkg::CTRL_REP_MASK : 8'h00);
  assign rep_match  = info.repeated && prior_valid &&
                      prior_source == info.source_address &&
                      prior_destination == info.destination_address &&
                      prior_length == info.lsdu_length &&
                      prior_check == norm_check;

  always_comb begin
    res = '0;
    update_prior = 1'b0;
    res.extended_frame = !info.std_format;
    if (byte_count_next < (info.std_format ? knxrx_pkg::STD_MIN_LEN
                                           : knxrx_pkg::EXT_MIN_LEN)) begin
      res.status = knxrx_pkg::ST_RUNT;
    end else if (byte_count_next < info.full_len) begin
      res.status = knxrx_pkg::ST_TRUNCATED;
    end else begin
      res.trimmed = byte_count_next > info.full_len;
      if (~running_xor_next != check_byte_next) begin
        res.status = knxrx_pkg::ST_CHECK_ERR;
      end else begin
        res.group_address       = info.group_address;
        res.source_address      = info.source_address;
        res.destination_address = info.destination_address;
        res.priority_res        = info.priority_res;
        res.routing_hops        = info.routing_hops;
        res.lsdu_length         = info.lsdu_length;
        res.repeated            = info.repeated;
        if (rep_match) begin
          res.status = knxrx_pkg::ST_REP_DROP;
        end else begin
          res.status   = knxrx_pkg::ST_ACCEPTED;
          update_prior = 1'b1;
        end
      end
    end
  end

  // frame state and prior identity
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count        <= '0;
      running_xor       <= '0;
      check_byte        <= '0;
      prior_valid       <= 1'b0;
      prior_source      <= '0;
      prior_destination <= '0;
      prior_length      <= '0;
      prior_check       <= '0;
    end else if (process) begin
      if (in_reg.last_byte) begin
        byte_count  <= '0;
        running_xor <= '0;
        check_byte  <= '0;
        if (update_prior) begin
          prior_valid       <= 1'b1;
          prior_source      <= info.source_address;
          prior_destination <= info.destination_address;
          prior_length      <= info.lsdu_length;
          prior_check       <= norm_check;
        end
      end else begin
        byte_count  <= byte_count_next;
        running_xor <= running_xor_next;
        check_byte  <= check_byte_next;
      end
    end
  end

  // header octets, no reset
  always_ff @(posedge clk) begin
    if (process) begin
      header_store <= hdr_cur;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (process && in_reg.last_byte) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (process && in_reg.last_byte) begin
      result_item <= res;
    end
  end

  `KNXRX_ASSERT_NEXT(a_frame_clear, process && in_reg.last_byte, byte_count == 9'd0 && running_xor == 8'h00 && check_byte == 8'h00, "frame state not cleared after final octet")
  `KNXRX_ASSERT_NOW(a_no_overwrite, in_valid && in_reg.last_byte && result_valid && result_stall, !process, "final octet processed over a stalled result")
  `KNXRX_ASSERT_NEXT(a_prior_set, process && in_reg.last_byte && res.status == knxrx_pkg::ST_ACCEPTED, prior_valid, "accepted frame did not record its identity")
  `KNXRX_ASSERT_NOW(a_short_zero, result_valid && (result_item.status == knxrx_pkg::ST_RUNT || result_item.status == knxrx_pkg::ST_TRUNCATED), result_item.lsdu_length == 9'd0 && !result_item.trimmed, "short frame result carries decoded fields")

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the bus frame receive checker: random frames, stalls and a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] octet_q_t[$];

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_OCTETS = 95;
  localparam int IDLE_MIX [4] = '{0, 70, 0, 22};
  localparam int STALL_MIX [4] = '{0, 0, 70, 22};

  // Predicts the verdict of every frame and checks the block's verdicts against it
  class frame_verdict_board;
    int         octet_count;
    logic [7:0] xor_acc;
    logic [7:0] hdr [knxrx_pkg::HDR_DEPTH];
    logic [7:0] chk;
    logic       have_prior;
    logic [15:0] prior_src;
    logic [15:0] prior_dst;
    logic [8:0] prior_len;
    logic [7:0] prior_chk;
    knxrx_pkg::result_t due_verdicts[$];
    int         errors;
    int         octets;
    int         checked;
    int         trimmed_seen;
    int         saturated_seen;
    int         status_seen [5];

    function new();
      octet_count = 0;
      xor_acc = '0;
      chk = '0;
      have_prior = 1'b0;
      prior_src = '0;
      prior_dst = '0;
      prior_len = '0;
      prior_chk = '0;
      foreach (hdr[i]) hdr[i] = '0;
    endfunction

    // Expected total frame length from the stored header
    function int frame_len();
      if ((hdr[0] & knxrx_pkg::CTRL_STD_MASK) != 0)
        return int'(knxrx_pkg::STD_MIN_LEN) + int'(hdr[5] & knxrx_pkg::LEN_FIELD_MASK);
      return int'(knxrx_pkg::EXT_MIN_LEN) + int'(hdr[6]);
    endfunction

    // Accepted octet: update frame state, queue a verdict on the final octet
    function void note_octet(knxrx_pkg::byte_t it);
      int         pos;
      logic       std_fr;
      logic [7:0] norm;
      knxrx_pkg::result_t r;
      pos = octet_count;
      octets++;
      if (pos < knxrx_pkg::HDR_DEPTH) begin
        hdr[pos] = it.data_byte;
        xor_acc ^= it.data_byte;
      end else if (pos < int'(knxrx_pkg::COUNT_MAX)) begin
        if (pos + 1 < frame_len()) xor_acc ^= it.data_byte;
        else if (pos + 1 == frame_len()) chk = it.data_byte;
      end
      if (octet_count < int'(knxrx_pkg::COUNT_MAX)) octet_count++;
      if (!it.last_byte) return;

      r = '0;
      std_fr = (hdr[0] & knxrx_pkg::CTRL_STD_MASK) != 0;
      r.extended_frame = !std_fr;
      if (octet_count == int'(knxrx_pkg::COUNT_MAX)) saturated_seen++;
      if (octet_count < int'(std_fr ? knxrx_pkg::STD_MIN_LEN : knxrx_pkg::EXT_MIN_LEN)) begin
        r.status = knxrx_pkg::ST_RUNT;
      end else if (octet_count < frame_len()) begin
        r.status = knxrx_pkg::ST_TRUNCATED;
      end else begin
        r.trimmed = octet_count > frame_len();
        if (~xor_acc != chk) begin
          r.status = knxrx_pkg::ST_CHECK_ERR;
        end else begin
          if (std_fr) begin
            r.group_address = hdr[5][7];
            r.source_address = {hdr[1], hdr[2]};
            r.destination_address = {hdr[3], hdr[4]};
            r.routing_hops = hdr[5][6:4];
            r.lsdu_length = {5'd0, hdr[5][3:0]} + 9'd1;
          end else begin
            r.group_address = hdr[1][7];
            r.source_address = {hdr[2], hdr[3]};
            r.destination_address = {hdr[4], hdr[5]};
            r.routing_hops = hdr[1][6:4];
            r.lsdu_length = {1'b0, hdr[6]} + 9'd1;
          end
          r.priority_res = hdr[0][3:2];
          r.repeated = (hdr[0] & knxrx_pkg::CTRL_REP_MASK) == 0;
          norm = r.repeated ? (chk ^ knxrx_pkg::CTRL_REP_MASK) : chk;
          // a repeat matching the last good frame is dropped, prior identity kept
          if (r.repeated && have_prior && prior_src == r.source_address &&
              prior_dst == r.destination_address && prior_len == r.lsdu_length &&
              prior_chk == norm) begin
            r.status = knxrx_pkg::ST_REP_DROP;
          end else begin
            r.status = knxrx_pkg::ST_ACCEPTED;
            have_prior = 1'b1;
            prior_src = r.source_address;
            prior_dst = r.destination_address;
            prior_len = r.lsdu_length;
            prior_chk = norm;
          end
        end
      end
      due_verdicts.push_back(r);
      octet_count = 0;
      xor_acc = '0;
      chk = '0;
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task cmp_field(string name, logic [15:0] got_v, logic [15:0] want_v);
      if (got_v !== want_v)
        report_mismatch($sformatf("verdict %0d %s: got 0x%0h, expected 0x%0h",
                                  checked, name, got_v, want_v));
    endtask

    // Accepted result: compare with the oldest predicted verdict
    task check_verdict(knxrx_pkg::result_t got);
      knxrx_pkg::result_t want;
      if (due_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict with no frame pending, status %0d", got.status));
        return;
      end
      want = due_verdicts.pop_front();
      checked++;
      status_seen[int'(want.status)]++;
      if (want.trimmed) trimmed_seen++;
      cmp_field("status", got.status, want.status);
      cmp_field("extended_frame", got.extended_frame, want.extended_frame);
      cmp_field("trimmed", got.trimmed, want.trimmed);
      cmp_field("group_address", got.group_address, want.group_address);
      cmp_field("source_address", got.source_address, want.source_address);
      cmp_field("destination_address", got.destination_address, want.destination_address);
      cmp_field("priority_res", got.priority_res, want.priority_res);
      cmp_field("routing_hops", got.routing_hops, want.routing_hops);
      cmp_field("lsdu_length", got.lsdu_length, want.lsdu_length);
      cmp_field("repeated", got.repeated, want.repeated);
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               byte_valid = 1'b0;
  logic               byte_stall;
  knxrx_pkg::byte_t   byte_item = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  knxrx_pkg::result_t result_item;

  int idle_pct = 0;
  int stall_pct = 0;
  int random_octets = 0;
  int quiet = 0;
  octet_q_t prev_good;
  frame_verdict_board board = new();

  knx_rx_frame_checker dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  always #6 clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watch both handshakes; also the watchdog on cycles with no request moving
  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) board.note_octet(byte_item);
    if (!rst && result_valid === 1'b1 && !result_stall) board.check_verdict(result_item);
    if ((byte_valid && byte_stall === 1'b0) || (result_valid === 1'b1 && !result_stall))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("Timed out after %0d cycles with no request moving.", QUIET_LIMIT);
      $display("knx_rx_frame_checker test failed");
      $finish;
    end
  end

  // Replace the last octet by the inverted XOR of the others
  function automatic octet_q_t seal(input octet_q_t f);
    logic [7:0] x;
    x = 8'h00;
    for (int i = 0; i < f.size() - 1; i++) x ^= f[i];
    f[f.size() - 1] = ~x;
    return f;
  endfunction

  // Well-formed frame with random header and payload
  function automatic octet_q_t make_frame(input logic ext, input int plen, input logic rep);
    octet_q_t   f;
    logic [7:0] ctl;
    logic [7:0] rnd;
    ctl = 8'($urandom);
    ctl[7] = ~ext;
    ctl[5] = ~rep;
    rnd = 8'($urandom);
    f.push_back(ctl);
    if (ext) begin
      repeat (5) f.push_back(8'($urandom));
      f.push_back(8'(plen));
    end else begin
      repeat (4) f.push_back(8'($urandom));
      f.push_back({rnd[7:4], 4'(plen)});
    end
    repeat (plen + 1) f.push_back(8'($urandom));
    f.push_back(8'h00);
    return seal(f);
  endfunction

  task automatic send_octet(input logic [7:0] d, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= {d, fin};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
  endtask

  task automatic send_frame(input octet_q_t f);
    foreach (f[i]) send_octet(f[i], i == f.size() - 1);
  endtask

  // One random frame: mostly well-formed, some repeats, damaged or noise
  task automatic random_frame();
    octet_q_t f;
    int       pick;
    int       n;
    logic     ext;
    pick = $urandom_range(99);
    ext = $urandom_range(1);
    if (ext && $urandom_range(19) == 0)
      f = make_frame(ext, $urandom_range(255, 16), $urandom_range(4) == 0);
    else
      f = make_frame(ext, $urandom_range(15), $urandom_range(4) == 0);
    if (pick < 12 && prev_good.size() != 0) begin
      // repetition of the last good frame with the repeat flag cleared
      f = prev_good;
      f[0] = f[0] & ~knxrx_pkg::CTRL_REP_MASK;
      f = seal(f);
    end else if (pick < 67) begin
      prev_good = f;
    end else if (pick < 75) begin
      n = $urandom_range(f.size() - 1);
      f[n] = f[n] ^ (8'h01 << $urandom_range(7));
    end else if (pick < 83) begin
      n = $urandom_range(f.size() - 1, 1);
      f = f[0:n-1];
    end else if (pick < 91) begin
      prev_good = f;
      repeat ($urandom_range(5, 1)) f.push_back(8'($urandom));
    end else begin
      f.delete();
      repeat ($urandom_range(24, 1)) f.push_back(8'($urandom));
    end
    random_octets += f.size();
    send_frame(f);
  endtask

  initial begin
    octet_q_t f;
    int       span;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: runts of both formats
    f = '{8'hFF};
    send_frame(f);
    f = '{8'h00};
    send_frame(f);
    // extreme header fields, one trailing octet
    f = seal('{8'hBC, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hF0, 8'h55, 8'h00});
    prev_good = f;
    f.push_back(8'hA5);
    send_frame(f);
    // same frame sent as a repeat, dropped
    f = prev_good;
    f[0] = f[0] & ~knxrx_pkg::CTRL_REP_MASK;
    send_frame(seal(f));
    // length field asks for nine octets, only eight arrive
    f = '{8'hB0, 8'h12, 8'h34, 8'h56, 8'h78, 8'h01, 8'h00, 8'h7F};
    send_frame(f);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = IDLE_MIX[ph];
      stall_pct = STALL_MIX[ph];
      if (ph == 3) begin
        // long stream: maximal extended frame, trailing octets past saturation
        f = make_frame(1'b1, 255, 1'b0);
        span = 512 + $urandom_range(10);
        while (f.size() < span) f.push_back(8'($urandom));
        send_frame(f);
      end
      while (random_octets < (ph + 1) * PHASE_OCTETS) random_frame();
    end
    byte_valid <= 1'b0;

    while (board.due_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d octets over four idle/stall mixes, %0d frames saturated the count.",
             board.octets, board.saturated_seen);
    $display("Verdicts: %0d accepted, %0d runt, %0d truncated, %0d check error, %0d repeats dropped, %0d trimmed.",
             board.status_seen[0], board.status_seen[1], board.status_seen[2],
             board.status_seen[3], board.status_seen[4], board.trimmed_seen);
    if (board.errors == 0) begin
      $display("knx_rx_frame_checker test passed");
    end else begin
      $display("knx_rx_frame_checker test failed");
    end
    $finish;
  end

endmodule
